>>> rtl/scatter_gather_request_slicer_top_macros.svh
// assertion macros shared by the scatter-gather request slicer
`ifndef SCATTER_GATHER_REQUEST_SLICER_TOP_MACROS_SVH
`define SCATTER_GATHER_REQUEST_SLICER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SGRS_ASSERT_NOW(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
		else $error("slicer check failed");

// next-cycle implication, disabled while reset is asserted
`define SGRS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
		else $error("slicer check failed");

`endif

>>> rtl/sgrs_pkg.sv
// shared types and constants for the scatter-gather request slicer
`timescale 1ns / 1ps

package sgrs_pkg;

	localparam int SECTOR_BYTES_DEF = 512;
	localparam int QUEUE_DEPTH_DEF  = 4;

	localparam int ADDR_W    = 32;
	localparam int OUT_LEN_W = 25;
	localparam int CFG_IDX_W = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PARTITION_START = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ADMIN_SPACE     = 8'd1;

	// command bits: bit 0 is the direction, bit 1 marks admin commands
	localparam int CMD_WRITE_BIT = 0;
	localparam int CMD_ADMIN_BIT = 1;

	// one classified entry handed from the front to the back
	typedef struct packed {
		logic              first;
		logic              last;
		logic              hit;
		logic              is_write;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] avail;
		logic [ADDR_W-1:0] target;
		logic [ADDR_W-1:0] dev_block;
	} front_item_t;

	// one descriptor in the output register
	typedef struct packed {
		logic [ADDR_W-1:0]    device_block;
		logic                 is_write;
		logic [ADDR_W-1:0]    out_addr;
		logic [OUT_LEN_W-1:0] out_len;
		logic                 out_last;
		logic                 list_short;
	} result_t;

endpackage

>>> rtl/scatter_gather_request_slicer_top.sv
// top level of the scatter-gather request slicer
`timescale 1ns / 1ps
`include "scatter_gather_request_slicer_top_macros.svh"

// Slices a block request and its incoming scatter-gather entries into a
// trimmed descriptor stream for one member disk.
// s_axis: one incoming entry per transfer; the first entry of a request has
// tuser[0] set and carries command, start block, block count and sector skip.
// m_axis: descriptors with the translated disk block and direction; tlast
// marks the descriptor that completes the byte count, tuser[1] flags a list
// that ran out early. Entries after completion, and skipped entries other than
// the last entry of a list that ran out early, give no descriptor.
// cfg: register writes (partition start, admin space), always ready, to be
// written while no request is in flight.
// Throughput is one entry per cycle while the queue has room. The front
// classifies each accepted entry into the queue; the back trims it into
// the output register, from which its descriptor is shown.
// When m_axis stalls, the queue (QUEUE_DEPTH entries) absorbs entries until
// full, then s_axis_tready drops. Reset clears the queue, the output register,
// the open request and both config registers.
module scatter_gather_request_slicer_top #(
	parameter int SECTOR_BYTES = sgrs_pkg::SECTOR_BYTES_DEF,
	parameter int QUEUE_DEPTH  = sgrs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sgrs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// entry_addr, entry_len, block_addr, block_count, start_sector
	input  logic [127:0]                   s_axis_tdata,
	// first_entry, cmd
	input  logic [2:0]                     s_axis_tuser,
	input  logic                           s_axis_tlast,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// device_block, out_addr, out_len, zero pad
	output logic [95:0]                    m_axis_tdata,
	// is_write, list_short
	output logic [1:0]                     m_axis_tuser,
	output logic                           m_axis_tlast
);
	import sgrs_pkg::*;

	logic        q_in_valid;
	logic        q_in_ready;
	front_item_t q_in_data;
	logic        q_out_valid;
	logic        q_out_ready;
	front_item_t q_out_data;
	result_t     res;

	assign cfg_ready = 1'b1;

	// classification of incoming entries
	sgrs_front #(
		.SECTOR_BYTES(SECTOR_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.first_entry (s_axis_tuser[0]),
		.last_entry  (s_axis_tlast),
		.entry_addr  (s_axis_tdata[31:0]),
		.entry_len   (s_axis_tdata[63:32]),
		.cmd         (s_axis_tuser[2:1]),
		.block_addr  (s_axis_tdata[95:64]),
		.block_count (s_axis_tdata[111:96]),
		.start_sector(s_axis_tdata[127:112]),
		.push_valid  (q_in_valid),
		.push_ready  (q_in_ready),
		.push_data   (q_in_data)
	);

	// decoupling queue
	sgrs_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(q_in_valid),
		.push_ready(q_in_ready),
		.push_data (q_in_data),
		.pop_valid (q_out_valid),
		.pop_ready (q_out_ready),
		.pop_data  (q_out_data)
	);

	// trimming and output
	sgrs_back #(
		.SECTOR_BYTES(SECTOR_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(q_out_valid),
		.pop_ready(q_out_ready),
		.pop_data (q_out_data),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (res)
	);

	// output packing
	assign m_axis_tdata = {7'b0, res.out_len, res.out_addr, res.device_block};
	assign m_axis_tuser = {res.list_short, res.is_write};
	assign m_axis_tlast = res.out_last;

	// a short list never also completes the request
	`SGRS_ASSERT_NOW(a_short_not_last, clk, arst_n, m_axis_tvalid && m_axis_tuser[1], !m_axis_tlast)
	// an accepted entry is waiting in the queue on the next cycle
	`SGRS_ASSERT_NEXT(a_accept_queued, clk, arst_n, s_axis_tvalid && s_axis_tready, q_out_valid)
	// nothing queued and nothing shown means no descriptor next cycle
	`SGRS_ASSERT_NEXT(a_no_phantom, clk, arst_n, !q_out_valid && !m_axis_tvalid, !m_axis_tvalid)

endmodule

>>> rtl/sgrs_front.sv
// front end: config registers, block translation and skip-region classification
`timescale 1ns / 1ps

module sgrs_front #(
	parameter int SECTOR_BYTES = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [sgrs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          first_entry,
	input  logic                          last_entry,
	input  logic [31:0]                   entry_addr,
	input  logic [31:0]                   entry_len,
	input  logic [1:0]                    cmd,
	input  logic [31:0]                   block_addr,
	input  logic [15:0]                   block_count,
	input  logic [15:0]                   start_sector,
	output logic                          push_valid,
	input  logic                          push_ready,
	output sgrs_pkg::front_item_t         push_data
);
	import sgrs_pkg::*;

	localparam int BYTE_W = 16 + $clog2(SECTOR_BYTES);

	logic [31:0]       part_start_q;
	logic [15:0]       admin_space_q;
	logic [BYTE_W-1:0] skip_left_q;
	logic              past_q;

	logic [BYTE_W-1:0] skip_cur;
	logic              past_cur;
	logic              hit;
	logic [BYTE_W-1:0] lead;
	logic              accept;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign accept     = in_valid && push_ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_start_q  <= '0;
			admin_space_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PARTITION_START: part_start_q  <= cfg_data;
				CFG_ADMIN_SPACE:     admin_space_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// skip region test against the bytes still to be skipped
	always_comb begin
		skip_cur = first_entry ? BYTE_W'(start_sector * SECTOR_BYTES) : skip_left_q;
		past_cur = first_entry ? 1'b0 : past_q;
		hit      = past_cur || (entry_len > 32'(skip_cur));
		lead     = past_cur ? '0 : skip_cur;
	end

	// classified entry
	always_comb begin
		push_data.first    = first_entry;
		push_data.last     = last_entry;
		push_data.hit      = hit;
		push_data.is_write = cmd[CMD_WRITE_BIT];
		push_data.addr     = entry_addr + 32'(lead);
		push_data.avail    = entry_len - 32'(lead);
		push_data.target   = 32'(block_count * SECTOR_BYTES);
		if (cmd[CMD_ADMIN_BIT])
			push_data.dev_block = block_addr + part_start_q;
		else
			push_data.dev_block = block_addr + 32'(admin_space_q) + part_start_q;
	end

	// skip state advances with every accepted entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_left_q <= '0;
			past_q      <= 1'b0;
		end else if (accept) begin
			past_q      <= hit;
			skip_left_q <= hit ? '0 : skip_cur - BYTE_W'(entry_len);
		end
	end

endmodule

>>> rtl/sgrs_queue.sv
// small queue of classified entries between front and back
`timescale 1ns / 1ps

module sgrs_queue #(
	parameter int DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  sgrs_pkg::front_item_t push_data,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output sgrs_pkg::front_item_t pop_data
);
	import sgrs_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	front_item_t      mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> rtl/sgrs_back.sv
// back end: byte accounting, trimming and the output register
`timescale 1ns / 1ps

module sgrs_back #(
	parameter int SECTOR_BYTES = 512
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  sgrs_pkg::front_item_t pop_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output sgrs_pkg::result_t     out_data
);
	import sgrs_pkg::*;

	localparam int BYTE_W = 16 + $clog2(SECTOR_BYTES);

	logic              busy_q;
	logic [BYTE_W-1:0] remain_q;
	logic [31:0]       dev_q;
	logic              wr_q;
	logic              out_valid_q;
	result_t           out_q;

	logic              pop;
	logic              open;
	logic [BYTE_W-1:0] remain;
	logic              take;
	logic [BYTE_W-1:0] len;
	logic              done;
	logic              short_list;
	logic              res_valid;
	result_t           res;

	assign pop_ready = !out_valid_q || out_ready;
	assign pop       = pop_valid && pop_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// trim against the bytes still owed to the request
	always_comb begin
		open       = pop_data.first ? (pop_data.target != '0) : busy_q;
		remain     = pop_data.first ? BYTE_W'(pop_data.target) : remain_q;
		take       = pop_data.avail >= 32'(remain);
		len        = take ? remain : BYTE_W'(pop_data.avail);
		done       = open && pop_data.hit && take;
		short_list = open && !done && pop_data.last;
		res_valid  = open && (pop_data.hit || short_list);
	end

	// descriptor fields
	always_comb begin
		res.device_block = pop_data.first ? pop_data.dev_block : dev_q;
		res.is_write     = pop_data.first ? pop_data.is_write : wr_q;
		res.out_addr     = pop_data.hit ? pop_data.addr : '0;
		res.out_len      = pop_data.hit ? OUT_LEN_W'(len) : '0;
		res.out_last     = done;
		res.list_short   = short_list;
	end

	// request state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			remain_q <= '0;
			dev_q    <= '0;
			wr_q     <= 1'b0;
		end else if (pop) begin
			busy_q   <= open && !done && !pop_data.last;
			remain_q <= (open && pop_data.hit) ? remain - len : remain;
			if (pop_data.first) begin
				dev_q <= pop_data.dev_block;
				wr_q  <= pop_data.is_write;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop)
			out_valid_q <= res_valid;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (pop && res_valid)
			out_q <= res;
	end

endmodule
